### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spanning edge filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define UFSEF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define UFSEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/ufsef_pkg.sv
// ----------------------------------------------------------------------------
// ufsef_pkg
// Types and constants of the union-find spanning edge filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ufsef_pkg;

    localparam int NUM_NODES = 256;
    localparam int NODE_W    = $clog2(NUM_NODES);
    localparam int LINK_W    = NODE_W + 1;
    localparam int SIZE_W    = NODE_W + 1;

    typedef logic [NODE_W-1:0] t_node;

    // top bit of a link marks a root
    localparam logic [LINK_W-1:0] ROOT_LINK = LINK_W'(1) << NODE_W;

    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [SIZE_W-1:0] size;
    } t_entry;

    localparam t_entry ENTRY_INIT = '{link: ROOT_LINK, size: SIZE_W'(1)};

    typedef struct packed {
        logic   clear;
        logic   rd_en;
        t_node  rd_addr;
        logic   wr_en;
        t_node  wr_addr;
        t_entry wr_data;
    } t_mem_req;

    typedef struct packed {
        logic       start_graph;
        logic [7:0] node_a;
        logic [7:0] node_b;
    } t_edge_in;

    typedef struct packed {
        logic       edge_accepted;
        logic [7:0] joined_root;
    } t_edge_out;

endpackage

### design/ufsef_forest_mem.sv
// ----------------------------------------------------------------------------
// ufsef_forest_mem
// Forest memory: parent link and subtree size per node, registered read,
// per-entry valid bits so that reset and graph start clear every entry together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ufsef_forest_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ufsef_pkg::t_mem_req i_req,
    output ufsef_pkg::t_entry   o_rd_entry
);
    import ufsef_pkg::*;

    t_entry                 r_mem [NUM_NODES];
    logic [NUM_NODES-1:0]   r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= !i_req.clear && r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_valid ? r_rd_data : ENTRY_INIT;

endmodule

### design/union_find_spanning_edge_filter.sv
// ----------------------------------------------------------------------------
// union_find_spanning_edge_filter
// Kruskal edge selection over a disjoint-set forest with union by size and
// full path compression; one edge per beat, one result per edge.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   edge in   start / busy         i_edge   (start_graph, node_a, node_b)
//   result    o_done (one cycle)   o_result (edge_accepted, joined_root)
//
// An edge holds busy while each endpoint in turn is walked up to its root and
// its path is compressed, then the roots are compared and joined; the tree
// depth of an endpoint is at most 8 under union by size, and each step is a
// read of the forest memory, with a write of the new link when compressing.
// Reset and start_graph clear the forest through valid bits.
// The result shows for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module union_find_spanning_edge_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ufsef_pkg::t_edge_in  i_edge,
    output logic                 o_done,
    output ufsef_pkg::t_edge_out o_result
);
    import ufsef_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_COMP   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_WIN    = 3'd4;

    logic [2:0]        r_state, n_state;
    logic              r_phase, n_phase;
    t_node             r_node_a, n_node_a;
    t_node             r_node_b, n_node_b;
    t_node             r_cur, n_cur;
    t_node             r_root_a, n_root_a;
    t_node             r_root_b, n_root_b;
    logic [SIZE_W-1:0] r_size_a, n_size_a;
    logic [SIZE_W-1:0] r_size_b, n_size_b;
    t_node             r_win_node, n_win_node;
    logic [SIZE_W-1:0] r_win_size, n_win_size;
    logic              r_done, n_done;
    t_edge_out         r_result, n_result;

    t_mem_req          mem_req;
    t_entry            rd_entry;
    logic              rd_is_root;
    t_node             rd_link;
    t_node             phase_start;
    t_node             phase_root;
    logic              phase_done;

    ufsef_forest_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

    assign rd_is_root  = rd_entry.link[LINK_W-1];
    assign rd_link     = rd_entry.link[NODE_W-1:0];
    assign phase_start = r_phase ? r_node_b : r_node_a;
    assign phase_root  = r_phase ? r_root_b : r_root_a;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_node_a   = r_node_a;
        n_node_b   = r_node_b;
        n_cur      = r_cur;
        n_root_a   = r_root_a;
        n_root_b   = r_root_b;
        n_size_a   = r_size_a;
        n_size_b   = r_size_b;
        n_win_node = r_win_node;
        n_win_size = r_win_size;
        n_done     = 1'b0;
        n_result   = r_result;
        mem_req    = '0;
        phase_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_node_a        = NODE_W'(i_edge.node_a);
                    n_node_b        = NODE_W'(i_edge.node_b);
                    mem_req.clear   = i_edge.start_graph;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = NODE_W'(i_edge.node_a);
                    n_cur           = NODE_W'(i_edge.node_a);
                    n_phase         = 1'b0;
                    n_state         = S_FIND;
                end
            end
            S_FIND: begin
                if (rd_is_root) begin
                    if (r_phase) begin
                        n_root_b = r_cur;
                        n_size_b = rd_entry.size;
                    end else begin
                        n_root_a = r_cur;
                        n_size_a = rd_entry.size;
                    end
                    if (phase_start == r_cur) begin
                        phase_done = 1'b1;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = phase_start;
                        n_cur           = phase_start;
                        n_state         = S_COMP;
                    end
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = rd_link;
                    n_cur           = rd_link;
                end
            end
            S_COMP: begin
                if (r_cur == phase_root) begin
                    phase_done = 1'b1;
                end else begin
                    // point this node straight at the root, advance along old link
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = r_cur;
                    mem_req.wr_data.link = {1'b0, phase_root};
                    mem_req.wr_data.size = rd_entry.size;
                    mem_req.rd_en        = 1'b1;
                    mem_req.rd_addr      = rd_link;
                    n_cur                = rd_link;
                end
            end
            S_DECIDE: begin
                n_done = 1'b1;
                if (r_root_a == r_root_b) begin
                    n_result.edge_accepted = 1'b0;
                    n_result.joined_root   = 8'(r_root_a);
                    n_state                = S_IDLE;
                end else begin
                    mem_req.wr_en = 1'b1;
                    if (r_size_a > r_size_b) begin
                        mem_req.wr_addr      = r_root_b;
                        mem_req.wr_data.link = {1'b0, r_root_a};
                        mem_req.wr_data.size = r_size_b;
                        n_win_node           = r_root_a;
                    end else begin
                        mem_req.wr_addr      = r_root_a;
                        mem_req.wr_data.link = {1'b0, r_root_b};
                        mem_req.wr_data.size = r_size_a;
                        n_win_node           = r_root_b;
                    end
                    n_win_size             = SIZE_W'(r_size_a + r_size_b);
                    n_result.edge_accepted = 1'b1;
                    n_result.joined_root   = 8'(n_win_node);
                    n_state                = S_WIN;
                end
            end
            S_WIN: begin
                mem_req.wr_en        = 1'b1;
                mem_req.wr_addr      = r_win_node;
                mem_req.wr_data.link = ROOT_LINK;
                mem_req.wr_data.size = r_win_size;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (phase_done) begin
            if (!r_phase) begin
                n_phase         = 1'b1;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_node_b;
                n_cur           = r_node_b;
                n_state         = S_FIND;
            end else begin
                n_state = S_DECIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node_a   <= n_node_a;
        r_node_b   <= n_node_b;
        r_cur      <= n_cur;
        r_root_a   <= n_root_a;
        r_root_b   <= n_root_b;
        r_size_a   <= n_size_a;
        r_size_b   <= n_size_b;
        r_win_node <= n_win_node;
        r_win_size <= n_win_size;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### design/ufsef_checker.sv
// ----------------------------------------------------------------------------
// ufsef_checker
// Port-level checks on the spanning edge filter: beat acceptance, result
// strobe timing relative to busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufsef_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    `UFSEF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `UFSEF_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))
    `UFSEF_ASSERT_NOW(a_busy_fall_done, i_clk, i_rst_n, $fell(busy), o_done || $past(o_done))
    `UFSEF_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)

endmodule

bind union_find_spanning_edge_filter ufsef_checker u_ufsef_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
